FILE: rtl/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared constants and types for the piecewise-linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;
	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int DW         = 32;

	localparam logic [1:0] REGION_INSIDE = 2'd0;
	localparam logic [1:0] REGION_LEFT   = 2'd1;
	localparam logic [1:0] REGION_RIGHT  = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef struct packed {
		logic ld_query;
		logic rd_first;
		logic rd_last;
		logic rd_mid;
		logic chk_ends;
		logic srch_step;
		logic rd_seg_a;
		logic rd_seg_b;
		logic setup;
		logic mul;
		logic div_start;
		logic div_step;
		logic finish;
	} plti_cmd_t;

	typedef struct packed {
		logic srch_done;
		logic div_done;
	} plti_sts_t;
endpackage

FILE: rtl/plti_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module plti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: rtl/plti_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_datapath
// Table storage, search registers, multiplier, serial divider and saturation.
// ----------------------------------------------------------------------------
module plti_datapath import plti_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_idx,
	input  logic [DW-1:0]      wr_x,
	input  logic [DW-1:0]      wr_y,
	input  logic [DW-1:0]      q_in,
	input  logic [CNT_W-1:0]   points_in_use,
	input  plti_cmd_t          cmd,
	output plti_sts_t          sts,
	output logic [DW-1:0]      res_y,
	output logic [1:0]         res_region,
	output logic               res_zero,
	output logic               res_sat
);
	logic [CNT_W-1:0] n_q, lo_q, cnt_q, step_c;
	logic signed [DW-1:0] q_q, x0_q, y0_q, xr, yr;
	logic [1:0] region_q;
	logic [IDX_W-1:0] a_q, addr;
	logic zero_q, neg_q;
	logic [DW-1:0] udx_q, udy_q, udq_q;
	logic [63:0] prod_q, rem_q, quot_q;
	logic [6:0] dcnt_q;
	logic [CNT_W-1:0] ncl, nm1;
	logic signed [DW:0] dx, dy, dq;
	logic [64:0] rem_sh, rem_sub;
	logic signed [34:0] sum;
	logic [IDX_W-1:0] mid_idx;

	assign ncl = (points_in_use < CNT_W'(2)) ? CNT_W'(2) :
		(points_in_use > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : points_in_use;
	assign nm1 = n_q - CNT_W'(1);
	assign step_c = cnt_q >> 1;
	assign mid_idx = IDX_W'(lo_q + step_c);

	always_comb begin
		addr = wr_idx;
		if (cmd.rd_first) addr = '0;
		else if (cmd.rd_last) addr = IDX_W'(nm1);
		else if (cmd.rd_mid) addr = mid_idx;
		else if (cmd.rd_seg_a) addr = a_q;
		else if (cmd.rd_seg_b) addr = a_q + IDX_W'(1);
	end

	plti_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(wr_en), .addr(addr), .wdata(wr_x), .rdata(xr));
	plti_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(wr_en), .addr(addr), .wdata(wr_y), .rdata(yr));

	assign dx = {xr[DW-1], xr} - {x0_q[DW-1], x0_q};
	assign dy = {yr[DW-1], yr} - {y0_q[DW-1], y0_q};
	assign dq = {q_q[DW-1], q_q} - {x0_q[DW-1], x0_q};
	assign rem_sh = {rem_q, quot_q[63]};
	assign rem_sub = rem_sh - {33'd0, udx_q};
	assign sts.srch_done = (cnt_q == '0);
	assign sts.div_done = (dcnt_q == '0);
	assign sum = neg_q ? (35'(y0_q) - 35'(signed'({1'b0, quot_q[33:0]})))
	                   : (35'(y0_q) + 35'(signed'({1'b0, quot_q[33:0]})));

	// quot_q[63:34] nonzero -> saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REGION_INSIDE;
			res_y <= '0;
			res_region <= REGION_INSIDE;
			res_zero <= 1'b0;
			res_sat <= 1'b0;
			dcnt_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.ld_query) begin
				q_q <= q_in;
				n_q <= ncl;
			end
			if (cmd.chk_ends) begin
				// xr holds x[n-1]; x0_q holds x[0]
				if (q_q <= x0_q) begin
					region_q <= REGION_LEFT;
					a_q <= '0;
					cnt_q <= '0;
				end else if (q_q >= xr) begin
					region_q <= REGION_RIGHT;
					a_q <= IDX_W'(n_q - CNT_W'(2));
					cnt_q <= '0;
				end else begin
					region_q <= REGION_INSIDE;
					lo_q <= '0;
					cnt_q <= n_q;
				end
			end else if (cmd.rd_first) begin
				// nothing
			end
			if (cmd.rd_last) x0_q <= xr;
			if (cmd.srch_step) begin
				if (!(q_q < xr)) begin
					lo_q <= lo_q + step_c + CNT_W'(1);
					cnt_q <= cnt_q - step_c - CNT_W'(1);
					if (cnt_q - step_c - CNT_W'(1) == '0)
						a_q <= IDX_W'(((lo_q + step_c + CNT_W'(1)) > nm1 ? nm1
							: (lo_q + step_c + CNT_W'(1))) - CNT_W'(1));
				end else begin
					cnt_q <= step_c;
					if (step_c == '0)
						a_q <= IDX_W'(((lo_q < CNT_W'(1)) ? CNT_W'(1)
							: (lo_q > nm1 ? nm1 : lo_q)) - CNT_W'(1));
				end
			end
			if (cmd.rd_seg_b) begin
				x0_q <= xr;
				y0_q <= yr;
			end
			if (cmd.setup) begin
				zero_q <= (dx == '0);
				udx_q <= DW'(dx[DW] ? -dx : dx);
				udy_q <= DW'(dy[DW] ? -dy : dy);
				udq_q <= DW'(dq[DW] ? -dq : dq);
				neg_q <= (dy[DW] != dq[DW]) && (dy != '0) && (dq != '0);
			end
			if (cmd.mul) prod_q <= 64'(udy_q) * 64'(udq_q);
			if (cmd.div_start) begin
				quot_q <= prod_q + 64'(udx_q >> 1);
				rem_q <= '0;
				dcnt_q <= 7'd64;
			end
			if (cmd.div_step) begin
				if (!rem_sub[64]) begin
					rem_q <= rem_sub[63:0];
					quot_q <= {quot_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					quot_q <= {quot_q[62:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 7'd1;
			end
			if (cmd.finish) begin
				res_region <= region_q;
				res_zero <= zero_q;
				if (zero_q) begin
					res_y <= y0_q;
					res_sat <= 1'b0;
				end else if ((quot_q[63:34] != '0) || (sum > 35'sh7FFFFFFF)
						|| (sum < -35'sh80000000)) begin
					res_y <= neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
					res_sat <= 1'b1;
				end else begin
					res_y <= sum[DW-1:0];
					res_sat <= 1'b0;
				end
			end
		end
	end
endmodule

FILE: rtl/plti_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer for query beats: end checks, binary search, multiply, divide.
// ----------------------------------------------------------------------------
module plti_ctrl import plti_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      in_query,
	input  logic      out_fire,
	input  plti_sts_t sts,
	output logic      busy,
	output logic      out_valid,
	output plti_cmd_t cmd
);
	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_FIRST = 12'b000000000010,
		S_LAST  = 12'b000000000100,
		S_ENDS  = 12'b000000001000,
		S_MID   = 12'b000000010000,
		S_CMP   = 12'b000000100000,
		S_SEGA  = 12'b000001000000,
		S_SEGB  = 12'b000010000000,
		S_SETUP = 12'b000100000000,
		S_MUL   = 12'b001000000000,
		S_DIV   = 12'b010000000000,
		S_FIN   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;
	logic   ov_q;
	logic   wait_q;

	assign out_valid = ov_q;
	assign busy = (state_q != S_IDLE) || wait_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: if (in_fire && in_query) begin
				cmd.ld_query = 1'b1;
				state_d = S_FIRST;
			end
			S_FIRST: begin cmd.rd_first = 1'b1; state_d = S_LAST; end
			S_LAST:  begin cmd.rd_last = 1'b1; state_d = S_ENDS; end
			S_ENDS:  begin cmd.chk_ends = 1'b1; state_d = S_MID; end
			S_MID: begin
				if (sts.srch_done) state_d = S_SEGA;
				else begin cmd.rd_mid = 1'b1; state_d = S_CMP; end
			end
			S_CMP:   begin cmd.srch_step = 1'b1; state_d = S_MID; end
			S_SEGA:  begin cmd.rd_seg_a = 1'b1; state_d = S_SEGB; end
			S_SEGB:  begin cmd.rd_seg_b = 1'b1; state_d = S_SETUP; end
			S_SETUP: begin cmd.setup = 1'b1; state_d = S_MUL; end
			S_MUL:   begin cmd.mul = 1'b1; state_d = S_DIV; end
			S_DIV: begin
				if (!wait_q) cmd.div_start = 1'b1;
				else if (!sts.div_done) cmd.div_step = 1'b1;
				else if (!ov_q || out_fire) state_d = S_FIN;
			end
			S_FIN:   begin cmd.finish = 1'b1; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			wait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) wait_q <= 1'b1;
			if (cmd.finish) wait_q <= 1'b0;
			if (cmd.finish) ov_q <= 1'b1;
			else if (out_fire) ov_q <= 1'b0;
		end
	end
endmodule

FILE: rtl/piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Breakpoint table with binary search, linear interpolation and extrapolation.
//
//  channel  | dir | content
//  s_axis   | in  | write or query beat
//  m_axis   | out | interpolated result beat
//  cfg      | in  | points_in_use
//
// Write beats are written into the table RAMs as they are accepted. Queries
// run the binary search over the x RAM port and the 64-step serial divider.
// Reset clears the sequencer and the result and sets points_in_use to 2; the
// table is undefined until written.
// A result waits in the output register; a stalled result holds the next query
// before its final stage.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator import plti_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action[0]
	input  logic         s_axis_tuser,
	// entry_index[5:0], entry_x[37:6], entry_y[69:38], query_x[101:70]
	input  logic [103:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// value_y[31:0]
	output logic [31:0]  m_axis_tdata,
	// region[1:0], zero_interval[2], saturated[3]
	output logic [3:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	logic [CNT_W-1:0] piu_q;
	logic in_fire, out_fire, busy, wr_en;
	plti_cmd_t cmd;
	plti_sts_t sts;
	logic [DW-1:0] ry;
	logic [1:0] rr;
	logic rz, rs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) piu_q <= CNT_W'(2);
		else if (cfg_we) piu_q <= cfg_wdata;
	end

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign wr_en = in_fire && (s_axis_tuser == ACT_WRITE);
	assign m_axis_tdata = ry;
	assign m_axis_tuser = {rs, rz, rr};

	plti_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_query(s_axis_tuser == ACT_QUERY), .out_fire(out_fire),
		.sts(sts), .busy(busy), .out_valid(m_axis_tvalid), .cmd(cmd));

	plti_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(s_axis_tdata[5:0]),
		.wr_x(s_axis_tdata[37:6]), .wr_y(s_axis_tdata[69:38]),
		.q_in(s_axis_tdata[101:70]), .points_in_use(piu_q), .cmd(cmd), .sts(sts),
		.res_y(ry), .res_region(rr), .res_zero(rz), .res_sat(rs));
endmodule

FILE: rtl/plti_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_checker
// Port-level checks on the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module plti_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         s_axis_tuser,
	input logic [103:0] s_axis_tdata,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [31:0]  m_axis_tdata,
	input logic [3:0]   m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[1:0] != 2'd3)
		else $error("bad region");
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[2] && m_axis_tuser[3]))
		else $error("zero interval flagged as saturated");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
		else $error("query beat did not hold off input");
endmodule

bind piecewise_linear_table_interpolator plti_checker u_plti_checker (.*);
